// ----- hdl/pps_pkg.sv -----
// Package for the periodic poll scheduler: heap entry type, sequencer states,
// function and status codes. No dependencies.
`default_nettype none

package pps_pkg;

  localparam int ID_W   = 16;
  localparam int PER_W  = 16;
  localparam int DUE_W  = 40;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;

  // Due time sits in the top bits so that one unsigned compare of the whole
  // entry orders by due time, then id, then period.
  typedef struct packed {
    logic [DUE_W-1:0] due;
    logic [ID_W-1:0]  user;
    logic [PER_W-1:0] period;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_SERVE = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_ROOT,
    ST_DN_RD,
    ST_DN_SEL,
    ST_DN_CMP,
    ST_WR,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/pps_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pps_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ----- hdl/pps_cmp.sv -----
// Shared entry comparator: tells whether entry a must be served before b.
// Depends on pps_pkg.
`default_nettype none

module pps_cmp (
  input  wire pps_pkg::entry_t a,
  input  wire pps_pkg::entry_t b,
  output logic                 a_first
);

  // Packed order is due, id, period, so a plain compare is lexicographic.
  assign a_first = (a < b);

endmodule

`default_nettype wire

// ----- hdl/periodic_poll_scheduler.sv -----
// Top level of the periodic poll scheduler: sequencer, heap count and output
// register. Depends on pps_pkg, pps_ram and pps_cmp.
`default_nettype none

// The block keeps up to MAX_USERS periodic users in a binary min-heap held in
// one dual-read RAM. An add transaction inserts a user whose first due time
// equals its period; a serve transaction returns the user with the earliest
// due time (ties go to the smaller id, then the smaller period), advances its
// due time by its period, saturating at 2^40-1, and sifts it back down; a
// clear transaction empties the table at once. Every input transaction
// produces exactly one result transaction. One sequencer and one shared
// comparator do all the heap work, so the block takes one transaction at a
// time and in_tready is low while it works. An add does one RAM read and
// one compare per heap level on the way up, and a serve does a root read,
// then per level on the way down a two-child read, a child select and a
// compare against the moving entry, and on reaching a leaf a final leaf
// check and write; a full, empty, clear or unused request goes straight to
// the result step. A result can wait in the output register while the next
// transaction is accepted; the sequencer only stalls at its last step if
// the previous result was not yet taken. The heap RAM needs no clearing
// after reset: only entries below the count are ever used.
module periodic_poll_scheduler #(
  parameter int MAX_USERS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] user_id, [31:16] period
  input  wire logic [1:0]  in_tuser,   // [1:0] func
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [15:0] served_id, [55:16] due_time
  output logic [1:0]       out_tuser   // [1:0] status
);

  localparam int AW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int CW = $clog2(MAX_USERS + 1);
  localparam int XW = AW + 2;   // wide enough for a right child index

  // Sequencer and heap state.
  pps_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    hole_r, hole_nxt;
  pps_pkg::entry_t  moving_r, moving_nxt;
  pps_pkg::entry_t  child_r, child_nxt;
  logic [AW-1:0]    child_idx_r, child_idx_nxt;
  logic             r_ok_r, r_ok_nxt;
  logic [AW-1:0]    r_idx_r, r_idx_nxt;
  logic [AW-1:0]    l_idx_r, l_idx_nxt;

  // Pending result and output register.
  logic [pps_pkg::ID_W-1:0]  res_id_r, res_id_nxt;
  logic [pps_pkg::DUE_W-1:0] res_due_r, res_due_nxt;
  pps_pkg::status_t          res_stat_r, res_stat_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [55:0]               out_data_r, out_data_nxt;
  logic [1:0]                out_user_r, out_user_nxt;

  // RAM and comparator hookup.
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr, ram_raddr_a, ram_raddr_b;
  pps_pkg::entry_t         ram_wdata;
  logic [pps_pkg::ENTRY_W-1:0] ram_rdata_a, ram_rdata_b;
  pps_pkg::entry_t         rd_a, rd_b;
  pps_pkg::entry_t         cmp_a, cmp_b;
  logic                    cmp_a_first;

  // Helper values.
  logic                     in_fire;
  pps_pkg::func_t           in_func;
  logic [pps_pkg::ID_W-1:0] in_user;
  logic [pps_pkg::PER_W-1:0] in_period;
  logic                     full;
  logic [XW-1:0]            l_wide, r_wide, count_wide;
  logic [AW-1:0]            parent_idx;
  logic [pps_pkg::DUE_W:0]  due_sum;
  logic [pps_pkg::DUE_W-1:0] due_adv;

  assign in_fire   = in_tvalid && in_tready;
  assign in_func   = pps_pkg::func_t'(in_tuser);
  assign in_user   = in_tdata[15:0];
  assign in_period = in_tdata[31:16];
  assign full      = (count_r == CW'(MAX_USERS));

  assign count_wide = XW'(count_r);
  assign l_wide     = {1'b0, hole_r, 1'b1};
  assign r_wide     = l_wide + XW'(1);
  assign parent_idx = (hole_r - AW'(1)) >> 1;

  assign rd_a = pps_pkg::entry_t'(ram_rdata_a);
  assign rd_b = pps_pkg::entry_t'(ram_rdata_b);

  // Saturating advance of the root's due time; a carry out means overflow.
  assign due_sum = {1'b0, rd_a.due} + (pps_pkg::DUE_W + 1)'(rd_a.period);
  assign due_adv = due_sum[pps_pkg::DUE_W] ? {pps_pkg::DUE_W{1'b1}}
                                           : due_sum[pps_pkg::DUE_W-1:0];

  pps_ram #(
    .WIDTH (pps_pkg::ENTRY_W),
    .DEPTH (MAX_USERS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  pps_cmp u_cmp (
    .a       (cmp_a),
    .b       (cmp_b),
    .a_first (cmp_a_first)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pps_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hole_r      <= hole_nxt;
    moving_r    <= moving_nxt;
    child_r     <= child_nxt;
    child_idx_r <= child_idx_nxt;
    r_ok_r      <= r_ok_nxt;
    r_idx_r     <= r_idx_nxt;
    l_idx_r     <= l_idx_nxt;
    res_id_r    <= res_id_nxt;
    res_due_r   <= res_due_nxt;
    res_stat_r  <= res_stat_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    hole_nxt      = hole_r;
    moving_nxt    = moving_r;
    child_nxt     = child_r;
    child_idx_nxt = child_idx_r;
    r_ok_nxt      = r_ok_r;
    r_idx_nxt     = r_idx_r;
    l_idx_nxt     = l_idx_r;
    res_id_nxt    = res_id_r;
    res_due_nxt   = res_due_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    in_tready   = (state_r == pps_pkg::ST_IDLE);
    ram_we      = 1'b0;
    ram_waddr   = hole_r;
    ram_wdata   = moving_r;
    // The root is read whenever the sequencer is idle, so a serve finds it
    // on the RAM output in the next cycle.
    ram_raddr_a = '0;
    ram_raddr_b = '0;
    cmp_a       = moving_r;
    cmp_b       = rd_a;

    case (state_r)
      pps_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_id_nxt   = '0;
          res_due_nxt  = '0;
          res_stat_nxt = pps_pkg::STAT_OK;
          case (in_func)
            pps_pkg::FUNC_ADD: begin
              if (full) begin
                res_stat_nxt = pps_pkg::STAT_FULL;
                state_nxt    = pps_pkg::ST_DONE;
              end else begin
                moving_nxt.due    = pps_pkg::DUE_W'(in_period);
                moving_nxt.user   = in_user;
                moving_nxt.period = in_period;
                hole_nxt          = count_r[AW-1:0];
                count_nxt         = count_r + CW'(1);
                state_nxt = (count_r == '0) ? pps_pkg::ST_WR : pps_pkg::ST_UP_RD;
              end
            end
            pps_pkg::FUNC_SERVE: begin
              if (count_r == '0) begin
                res_stat_nxt = pps_pkg::STAT_EMPTY;
                state_nxt    = pps_pkg::ST_DONE;
              end else begin
                state_nxt = pps_pkg::ST_ROOT;
              end
            end
            pps_pkg::FUNC_CLEAR: begin
              count_nxt = '0;
              state_nxt = pps_pkg::ST_DONE;
            end
            default: begin
              state_nxt = pps_pkg::ST_DONE;
            end
          endcase
        end
      end

      pps_pkg::ST_UP_RD: begin
        ram_raddr_a = parent_idx;
        state_nxt   = pps_pkg::ST_UP_CMP;
      end

      pps_pkg::ST_UP_CMP: begin
        // The parent read in the previous cycle is on port A.
        cmp_a  = moving_r;
        cmp_b  = rd_a;
        ram_we = 1'b1;
        if (cmp_a_first) begin
          ram_wdata = rd_a;
          hole_nxt  = parent_idx;
          state_nxt = (parent_idx == '0) ? pps_pkg::ST_WR : pps_pkg::ST_UP_RD;
        end else begin
          ram_wdata = moving_r;
          state_nxt = pps_pkg::ST_DONE;
        end
      end

      pps_pkg::ST_ROOT: begin
        res_id_nxt        = rd_a.user;
        res_due_nxt       = rd_a.due;
        moving_nxt        = rd_a;
        moving_nxt.due    = due_adv;
        hole_nxt          = '0;
        state_nxt         = pps_pkg::ST_DN_RD;
      end

      pps_pkg::ST_DN_RD: begin
        if (l_wide >= count_wide) begin
          state_nxt = pps_pkg::ST_WR;
        end else begin
          ram_raddr_a = l_wide[AW-1:0];
          ram_raddr_b = r_wide[AW-1:0];
          l_idx_nxt   = l_wide[AW-1:0];
          r_idx_nxt   = r_wide[AW-1:0];
          r_ok_nxt    = (r_wide < count_wide);
          state_nxt   = pps_pkg::ST_DN_SEL;
        end
      end

      pps_pkg::ST_DN_SEL: begin
        // Pick the earlier of the two children; the right one only if present.
        cmp_a = rd_b;
        cmp_b = rd_a;
        if (r_ok_r && cmp_a_first) begin
          child_nxt     = rd_b;
          child_idx_nxt = r_idx_r;
        end else begin
          child_nxt     = rd_a;
          child_idx_nxt = l_idx_r;
        end
        state_nxt = pps_pkg::ST_DN_CMP;
      end

      pps_pkg::ST_DN_CMP: begin
        cmp_a  = child_r;
        cmp_b  = moving_r;
        ram_we = 1'b1;
        if (cmp_a_first) begin
          ram_wdata = child_r;
          hole_nxt  = child_idx_r;
          state_nxt = pps_pkg::ST_DN_RD;
        end else begin
          ram_wdata = moving_r;
          state_nxt = pps_pkg::ST_DONE;
        end
      end

      pps_pkg::ST_WR: begin
        ram_we    = 1'b1;
        ram_wdata = moving_r;
        state_nxt = pps_pkg::ST_DONE;
      end

      pps_pkg::ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_due_r, res_id_r};
          out_user_nxt  = res_stat_r;
          state_nxt     = pps_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pps_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire
